// ===== rtl/rlc_pkg.sv =====
// Shared constants, codes and types of the byte run-length codec.
package rlc_pkg;

    localparam int MAGIC_LEN = 7;
    localparam int OUT_LANES = 8;
    localparam int MAX_RUN   = 255;
    localparam int CFG_W     = 56;
    localparam int PACK_BYTES = 11;
    localparam int PACK_W    = 8 * PACK_BYTES;
    localparam int LEN_W     = 9;

    localparam logic [CFG_W-1:0] MAGIC_RESET = 56'h0A31454C525A42;

    // register indexes
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_MAGIC = 1'b1;

    // mode values
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef logic [7:0] byte_t;

    // Work handed from the stream front end to the emitter.
    typedef struct packed {
        logic              dec;
        byte_t             fill;
        logic [PACK_W-1:0] pack_data;
        logic [LEN_W-1:0]  len;
        logic              done;
        logic              bad;
    } load_t;

endpackage

// ===== rtl/rlc_stream_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface rlc_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output has_byte, output data_byte, output end_of_data,
                    input ready);
    modport sink   (input valid, input has_byte, input data_byte, input end_of_data,
                    output ready);
    modport mon    (input valid, input ready, input has_byte, input data_byte,
                    input end_of_data);
endinterface

interface rlc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        stream_done;
    logic        bad_payload;

    modport source (output valid, output out_bytes, output byte_count, output stream_done,
                    output bad_payload, input ready);
    modport sink   (input valid, input out_bytes, input byte_count, input stream_done,
                    input bad_payload, output ready);
    modport mon    (input valid, input ready, input out_bytes, input byte_count,
                    input stream_done, input bad_payload);
endinterface

// ===== rtl/rlc_emitter.sv =====
// Chunk sequencer: slices one item's output into results of up to eight bytes.
module rlc_emitter
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load_valid,
    input  rlc_pkg::load_t load,
    output logic          busy,
    rlc_out_if.source     result
);
    import rlc_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic              state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]  rem_reg;
    logic [PACK_W-1:0] data_reg;
    byte_t             fill_reg;
    logic              dec_reg, done_reg, bad_reg;
    logic [63:0]       word_reg;
    logic [3:0]        count_reg;
    logic              sdone_reg, sbad_reg;

    logic              slot_free;
    logic              last;
    logic [3:0]        cnt;
    logic [63:0]       word;
    logic              step;

    assign slot_free = !out_valid_reg || result.ready;
    assign step      = (state_reg == S_EMIT) && slot_free;
    assign last      = rem_reg <= LEN_W'(OUT_LANES);
    assign cnt       = last ? rem_reg[3:0] : 4'(OUT_LANES);

    always_comb
    begin
        for (int j = 0; j < OUT_LANES; j++)
        begin
            if (4'(j) < cnt)
                word[8*j +: 8] = dec_reg ? fill_reg : data_reg[8*j +: 8];
            else
                word[8*j +: 8] = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load_valid)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free && last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load_valid && state_reg == S_IDLE)
        begin
            rem_reg  <= load.len;
            data_reg <= load.pack_data;
            fill_reg <= load.fill;
            dec_reg  <= load.dec;
            done_reg <= load.done;
            bad_reg  <= load.bad;
        end
        else if (step)
        begin
            rem_reg  <= rem_reg - LEN_W'(cnt);
            data_reg <= data_reg >> 64;
        end
        if (step)
        begin
            word_reg  <= word;
            count_reg <= cnt;
            sdone_reg <= last && done_reg;
            sbad_reg  <= last && done_reg && bad_reg;
        end
    end

    assign busy               = (state_reg == S_EMIT);
    assign result.valid       = out_valid_reg;
    assign result.out_bytes   = word_reg;
    assign result.byte_count  = count_reg;
    assign result.stream_done = sdone_reg;
    assign result.bad_payload = sbad_reg;

endmodule

// ===== rtl/byte_run_length_codec.sv =====
// Top level of the byte run-length codec: stream state, header logic and emitter.
//
//  channel   | dir  | handshake     | payload
//  ----------+------+---------------+-------------------------------------------------
//  item      | in   | valid/ready   | has_byte, data_byte[7:0], end_of_data
//  result    | out  | valid/ready   | out_bytes[63:0], byte_count[3:0], stream_done,
//            |      |               | bad_payload
//  cfg       | in   | cfg_we only   | cfg_index (0 mode, 1 magic_word), cfg_data[55:0]
//
// An accepted request updates the stream state in its accept cycle and hands the
// bytes it produces to the emitter, which sends one result of up to eight bytes per
// cycle while the result channel does not stall. A request that yields bytes (or
// only an end marker) keeps item.ready low until the emitter has moved its last
// result into the result register; the header and the pairs of one encoded byte
// leave together in its results.
// Requests that yield nothing are taken back to back. The result register holds a
// stalled result; the emitter steps only when that register is free, so a stalled
// result also lengthens a request that is still being emitted.
// rst_n is asynchronous, active low; it clears control state and the stream state.
module byte_run_length_codec
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [rlc_pkg::CFG_W-1:0]  cfg_data,
    rlc_in_if.sink                     item,
    rlc_out_if.source                  result
);
    import rlc_pkg::*;

    // configuration
    logic              mode_reg;
    logic [CFG_W-1:0]  magic_reg;

    // encoder state
    logic              header_sent_reg, header_sent_next;
    byte_t             run_value_reg, run_value_next;
    byte_t             run_length_reg, run_length_next;
    // decoder state
    logic [2:0]        magic_pos_reg, magic_pos_next;
    logic              header_failed_reg, header_failed_next;
    byte_t             held_count_reg, held_count_next;
    logic              second_reg, second_next;

    logic              busy;
    logic              accept;
    logic              has, fin;
    byte_t             b;

    // encoder datapath
    logic              hdr, run_cont, brk, pair_a, pair_b;
    byte_t             new_len, new_val;
    logic [31:0]       pairs;
    logic [2:0]        pair_len;
    logic [PACK_W-1:0] enc_data;
    logic [3:0]        enc_len;

    // decoder datapath
    logic              in_header, mismatch, dec_emit;
    byte_t             magic_byte;

    load_t             load;
    logic              load_valid;

    assign has    = item.has_byte;
    assign fin    = item.end_of_data;
    assign b      = item.data_byte;
    assign accept = item.valid && item.ready;
    assign item.ready = !busy;

    // ---- encoder: header, run extension and pair cuts ----
    assign hdr      = !header_sent_reg && (has || fin);
    assign run_cont = (run_length_reg != 8'd0) && (b == run_value_reg)
                      && (run_length_reg < 8'(MAX_RUN));
    assign brk      = has && !run_cont;
    assign pair_a   = brk && (run_length_reg != 8'd0);
    assign new_len  = has ? (brk ? 8'd1 : run_length_reg + 8'd1) : run_length_reg;
    assign new_val  = (has && brk) ? b : run_value_reg;
    assign pair_b   = fin && (new_len != 8'd0);

    always_comb
    begin
        case ({pair_a, pair_b})
            2'b11:
            begin
                pairs    = {new_val, new_len, run_value_reg, run_length_reg};
                pair_len = 3'd4;
            end
            2'b10:
            begin
                pairs    = {16'h0000, run_value_reg, run_length_reg};
                pair_len = 3'd2;
            end
            2'b01:
            begin
                pairs    = {16'h0000, new_val, new_len};
                pair_len = 3'd2;
            end
            default:
            begin
                pairs    = 32'h0;
                pair_len = 3'd0;
            end
        endcase
    end

    // header bytes go first, pairs follow
    assign enc_data = hdr ? {pairs, magic_reg} : {56'h0, pairs};
    assign enc_len  = (hdr ? 4'(MAGIC_LEN) : 4'd0) + {1'b0, pair_len};

    // ---- decoder: header check, then count/value pairs ----
    assign in_header  = magic_pos_reg < 3'(MAGIC_LEN);
    assign magic_byte = magic_reg[8*magic_pos_reg +: 8];
    assign mismatch   = b != magic_byte;
    assign dec_emit   = has && !in_header && !header_failed_reg && second_reg;

    always_comb
    begin
        header_sent_next   = header_sent_reg;
        run_value_next     = run_value_reg;
        run_length_next    = run_length_reg;
        magic_pos_next     = magic_pos_reg;
        header_failed_next = header_failed_reg;
        held_count_next    = held_count_reg;
        second_next        = second_reg;
        if (mode_reg == MODE_ENCODE)
        begin
            header_sent_next = header_sent_reg || hdr;
            run_value_next   = new_val;
            run_length_next  = new_len;
        end
        else if (has)
        begin
            if (in_header)
            begin
                header_failed_next = header_failed_reg || mismatch;
                magic_pos_next     = magic_pos_reg + 3'd1;
            end
            else if (!header_failed_reg)
            begin
                if (!second_reg)
                begin
                    held_count_next = b;
                    second_next     = 1'b1;
                end
                else
                    second_next = 1'b0;
            end
        end
    end

    // ---- hand-off to the emitter ----
    always_comb
    begin
        load.dec       = (mode_reg == MODE_DECODE);
        load.fill      = b;
        load.pack_data = enc_data;
        load.done      = fin;
        load.bad       = (mode_reg == MODE_DECODE)
                         && (header_failed_next || magic_pos_next < 3'(MAGIC_LEN));
        if (mode_reg == MODE_DECODE)
            load.len = dec_emit ? {1'b0, held_count_reg} : '0;
        else
            load.len = LEN_W'(enc_len);
    end

    assign load_valid = accept && ((load.len != '0) || fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_ENCODE;
            magic_reg         <= MAGIC_RESET;
            header_sent_reg   <= 1'b0;
            run_value_reg     <= '0;
            run_length_reg    <= '0;
            magic_pos_reg     <= '0;
            header_failed_reg <= 1'b0;
            held_count_reg    <= '0;
            second_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MODE)
            begin
                // a mode change restarts the stream
                mode_reg          <= cfg_data[0];
                header_sent_reg   <= 1'b0;
                run_value_reg     <= '0;
                run_length_reg    <= '0;
                magic_pos_reg     <= '0;
                header_failed_reg <= 1'b0;
                held_count_reg    <= '0;
                second_reg        <= 1'b0;
            end
            else if (cfg_index == REG_MAGIC)
                magic_reg <= cfg_data;
        end
        else if (accept)
        begin
            if (fin)
            begin
                // end of stream: back to the reset state
                header_sent_reg   <= 1'b0;
                run_value_reg     <= '0;
                run_length_reg    <= '0;
                magic_pos_reg     <= '0;
                header_failed_reg <= 1'b0;
                held_count_reg    <= '0;
                second_reg        <= 1'b0;
            end
            else
            begin
                header_sent_reg   <= header_sent_next;
                run_value_reg     <= run_value_next;
                run_length_reg    <= run_length_next;
                magic_pos_reg     <= magic_pos_next;
                header_failed_reg <= header_failed_next;
                held_count_reg    <= held_count_next;
                second_reg        <= second_next;
            end
        end
    end

    rlc_emitter u_emitter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load       (load),
        .busy       (busy),
        .result     (result)
    );

endmodule

// ===== rtl/rlc_checker.sv =====
// Port-level checks on the result channel of the codec, bound to the top level.
module rlc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [63:0] out_bytes,
    input logic [3:0]  byte_count,
    input logic        stream_done,
    input logic        bad_payload
);

    // a stalled result holds its bytes, byte count and done flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(out_bytes)
            && $stable(byte_count) && $stable(stream_done))
        else $error("stalled result changed");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> byte_count <= 4'd8)
        else $error("byte_count above eight");

    // an empty result only closes a stream
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        valid && byte_count == 4'd0 |-> stream_done)
        else $error("empty result before stream end");

    // a bad header yields no data and only on the end result
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        valid && bad_payload |-> stream_done && byte_count == 4'd0)
        else $error("bad_payload with data or without stream_done");

endmodule

bind byte_run_length_codec rlc_checker u_rlc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result.valid),
    .ready       (result.ready),
    .out_bytes   (result.out_bytes),
    .byte_count  (result.byte_count),
    .stream_done (result.stream_done),
    .bad_payload (result.bad_payload)
);
